// ===== rtl/light_pulse_byte_receiver_top_defines.svh =====
// ----------------------------------------------------------------------------
// Light pulse byte receiver: assertion macros
// Shared concurrent-assertion wrappers for the receiver checkers.
// ----------------------------------------------------------------------------
`ifndef LIGHT_PULSE_BYTE_RECEIVER_TOP_DEFINES_SVH
`define LIGHT_PULSE_BYTE_RECEIVER_TOP_DEFINES_SVH

// Property checked on every clock edge outside of reset
`define LPBR_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every clock edge, reset included
`define LPBR_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/lpbr_pkg.sv =====
// ----------------------------------------------------------------------------
// lpbr_pkg
// Shared types and constants of the light pulse byte receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpbr_pkg;

  // Fixed field widths
  localparam int BYTE_W = 8;
  localparam int TICK_W = 16;
  localparam int CFG_W  = 16;
  localparam int CFG_IDX_W = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT_LEVEL    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_MARGIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_PERIOD_TICKS = 2'd2;

  // Register reset values
  localparam logic [CFG_W-1:0]  RST_AMBIENT_LEVEL = 16'd0;
  localparam logic [CFG_W-1:0]  RST_LIGHT_MARGIN  = 16'd10;
  localparam logic [TICK_W-1:0] RST_BIT_PERIOD    = 16'd1000;

  // Frame unit status toward the output stage
  typedef struct packed {
    logic              emit;     // current state emits a byte on the next step
    logic [BYTE_W-1:0] rx_byte;  // byte assembled so far
  } lpbr_frm_t;

endpackage

// ===== rtl/lpbr_frame.sv =====
// ----------------------------------------------------------------------------
// lpbr_frame
// Configuration registers, light detect and the frame timing/shift state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpbr_frame #(
  parameter int BIT_COUNT    = 8,
  parameter int SAMPLE_WIDTH = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lpbr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lpbr_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            step,
  input  logic [SAMPLE_WIDTH-1:0]         sample,
  output lpbr_pkg::lpbr_frm_t             frm
);
  import lpbr_pkg::*;

  localparam int IDX_W = $clog2(BIT_COUNT + 1);
  localparam logic [IDX_W-1:0] BIT_LAST = IDX_W'(BIT_COUNT);

  logic [SAMPLE_WIDTH-1:0] ambient_r;
  logic [SAMPLE_WIDTH-1:0] margin_r;
  logic [TICK_W-1:0]       period_r;

  logic                    receiving_r, receiving_nxt;
  logic [TICK_W-1:0]       tick_r, tick_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic [BYTE_W-1:0]       shift_r, shift_nxt;

  logic [SAMPLE_WIDTH:0]   limit;
  logic                    light;
  logic [TICK_W-1:0]       tick_inc;
  logic                    period_end;
  logic                    bits_done;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ambient_r <= RST_AMBIENT_LEVEL[SAMPLE_WIDTH-1:0];
      margin_r  <= RST_LIGHT_MARGIN[SAMPLE_WIDTH-1:0];
      period_r  <= RST_BIT_PERIOD;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_AMBIENT_LEVEL:    ambient_r <= cfg_wdata[SAMPLE_WIDTH-1:0];
        CFG_LIGHT_MARGIN:     margin_r  <= cfg_wdata[SAMPLE_WIDTH-1:0];
        CFG_BIT_PERIOD_TICKS: period_r  <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Light detect: compare one bit wider so the threshold never wraps
  assign limit = {1'b0, ambient_r} + {1'b0, margin_r};
  assign light = {1'b0, sample} > limit;

  // Bit period timing
  assign tick_inc   = tick_r + 1'b1;
  assign period_end = (tick_inc == period_r);
  assign bits_done  = !(idx_r < BIT_LAST);

  // Frame state update for one sample
  always_comb begin
    receiving_nxt = receiving_r;
    tick_nxt      = tick_r;
    idx_nxt       = idx_r;
    shift_nxt     = shift_r;
    if (step) begin
      if (!receiving_r) begin
        if (light) begin
          receiving_nxt = 1'b1;
          tick_nxt      = '0;
          idx_nxt       = '0;
          shift_nxt     = '0;
        end
      end else if (!period_end) begin
        tick_nxt = tick_inc;
      end else begin
        tick_nxt = '0;
        if (!bits_done) begin
          shift_nxt = {shift_r[BYTE_W-2:0], light};
          idx_nxt   = idx_r + 1'b1;
        end else begin
          receiving_nxt = 1'b0;
          idx_nxt       = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      receiving_r <= 1'b0;
      tick_r      <= '0;
      idx_r       <= '0;
      shift_r     <= '0;
    end else begin
      receiving_r <= receiving_nxt;
      tick_r      <= tick_nxt;
      idx_r       <= idx_nxt;
      shift_r     <= shift_nxt;
    end
  end

  // Emit depends on state only, not on the sample
  assign frm.emit    = receiving_r && period_end && bits_done;
  assign frm.rx_byte = shift_r;

endmodule

// ===== rtl/light_pulse_byte_receiver_top.sv =====
// ----------------------------------------------------------------------------
// light_pulse_byte_receiver_top
// Start-bit serial receiver on light samples: one byte per frame, MSB first.
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  --------+------------------------------------+----------
//  in      | in_valid, in_stall, in_light_sample| sample in
//  out     | out_valid, out_stall, out_rx_byte  | byte out
//  cfg     | cfg_we, cfg_idx, cfg_wdata         | reg write
//
//  One sample is taken every cycle while in_stall is low; it is registered,
//  then processed in the frame unit; a byte is registered into the out slot
//  when the sample completing the frame is processed.
//  in_stall rises only when the frame-completing sample meets a stalled byte.
//  Reset (rst_n low, synchronous) clears the frame state and output valid and
//  loads the register defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module light_pulse_byte_receiver_top #(
  parameter int BIT_COUNT    = 8,
  parameter int SAMPLE_WIDTH = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [SAMPLE_WIDTH-1:0]         in_light_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [lpbr_pkg::BYTE_W-1:0]     out_rx_byte,
  input  logic                            cfg_we,
  input  logic [lpbr_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lpbr_pkg::CFG_W-1:0]      cfg_wdata
);
  import lpbr_pkg::*;

  logic                    s1_vld_r;
  logic [SAMPLE_WIDTH-1:0] s1_sample_r;
  logic                    out_vld_r, out_vld_nxt;
  logic [BYTE_W-1:0]       out_byte_r;
  logic                    hold;
  logic                    step;
  lpbr_frm_t               frm;

  // Hold only when a byte is due and the output slot is blocked
  assign hold     = s1_vld_r && frm.emit && out_vld_r && out_stall;
  assign step     = s1_vld_r && !hold;
  assign in_stall = hold;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (!hold) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !hold) begin
      s1_sample_r <= in_light_sample;
    end
  end

  lpbr_frame #(
    .BIT_COUNT    (BIT_COUNT),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_frame (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .step      (step),
    .sample    (s1_sample_r),
    .frm       (frm)
  );

  // Output register
  always_comb begin
    out_vld_nxt = out_vld_r && out_stall;
    if (step && frm.emit) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && frm.emit) begin
      out_byte_r <= frm.rx_byte;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_rx_byte = out_byte_r;

endmodule

// ===== rtl/lpbr_checker.sv =====
// ----------------------------------------------------------------------------
// lpbr_checker
// Port-level checks of the light pulse byte receiver, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "light_pulse_byte_receiver_top_defines.svh"

module lpbr_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [lpbr_pkg::BYTE_W-1:0] out_rx_byte
);
  import lpbr_pkg::*;

  // A stalled byte stays offered
  `LPBR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "out request dropped")
  // A stalled byte keeps its value
  `LPBR_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(out_rx_byte), "out byte changed")
  // Input back-pressure only comes from a blocked output
  `LPBR_ASSERT(a_in_stall_cause, in_stall |-> out_valid && out_stall, "stall without blocked out")
  // A stalled sample request stays offered
  `LPBR_ASSERT(a_in_hold, in_valid && in_stall |=> in_valid, "in request dropped")
  // Reset empties the output slot
  `LPBR_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid, "out valid after reset")

endmodule

bind light_pulse_byte_receiver_top lpbr_checker u_lpbr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_rx_byte (out_rx_byte)
);
